@@ rtl/assert_macros.svh @@
// Assertion macros shared by the beat interval rate averager RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIRA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define BIRA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/bira_pkg.sv @@
// Package for the beat interval rate averager: widths, register codes,
// reset values, controller states and inter-module structs. No dependencies.
package bira_pkg;

  // Field widths.
  localparam int unsigned IR_W     = 18;
  localparam int unsigned DEB_W    = 16;
  localparam int unsigned RATE_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HR_W     = 9;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;

  // Rate history geometry.
  localparam int unsigned HIST_DEPTH = 8;
  localparam int unsigned HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int unsigned SUM_W      = RATE_W + $clog2(HIST_DEPTH + 1);

  // Serial divider geometry: 16-bit dividend and divisor, one bit per step.
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned DIV_CW  = $clog2(DIV_W);

  // Beats per minute numerator: milliseconds in one minute.
  localparam logic [DIV_W-1:0] RATE_NUM = DIV_W'(60000);

  // Register reset values.
  localparam logic [IR_W-1:0]   IR_FLOOR_RST = IR_W'(50000);
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(500);
  localparam logic [RATE_W-1:0] MIN_RATE_RST = RATE_W'(40);
  localparam logic [RATE_W-1:0] MAX_RATE_RST = RATE_W'(120);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IR_FLOOR = 2'd0,
    REG_DEBOUNCE = 2'd1,
    REG_MIN_RATE = 2'd2,
    REG_MAX_RATE = 2'd3
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RDIV,
    S_CHK,
    S_MSTART,
    S_MDIV,
    S_DONE
  } state_e;

  // Command to the serial divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_cmd_t;

  // Status from the serial divider; quotient and remainder hold until restart.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_stat_t;

  // Write request to the rate history.
  typedef struct packed {
    logic              we;
    logic [RATE_W-1:0] rate;
  } hist_wr_t;

  // Status from the rate history.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [FILL_W-1:0] filled;
  } hist_stat_t;

endpackage

@@ rtl/bira_sdiv.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, DIV_W bits in all.
// Depends on bira_pkg for widths and the command and status structs.
module bira_sdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bira_pkg::div_cmd_t  cmd_i,
  output bira_pkg::div_stat_t stat_o
);

  logic [bira_pkg::DIV_W-1:0]  quo_q, quo_d;
  logic [bira_pkg::DIV_W-1:0]  rem_q, rem_d;
  logic [bira_pkg::DIV_W-1:0]  dvs_q, dvs_d;
  logic [bira_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [bira_pkg::DIV_W:0]    trial;
  logic [bira_pkg::DIV_W:0]    diff;
  logic                        fits;

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial = {rem_q, quo_q[bira_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = !diff[bira_pkg::DIV_W];

  // Step sequencing; the dividend shifts out as the quotient shifts in.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      quo_d  = cmd_i.dividend;
      rem_d  = '0;
      dvs_d  = cmd_i.divisor;
      cnt_d  = '1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[bira_pkg::DIV_W-2:0], fits};
      rem_d = fits ? diff[bira_pkg::DIV_W-1:0] : trial[bira_pkg::DIV_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = quo_q;
  assign stat_o.rem  = rem_q;

endmodule

@@ rtl/bira_hist.sv @@
// Rate history ring with a running total and a saturating fill count.
// Depends on bira_pkg for the history geometry and the interface structs.
module bira_hist (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bira_pkg::hist_wr_t   wr_i,
  output bira_pkg::hist_stat_t stat_o
);

  logic [bira_pkg::RATE_W-1:0]  ring_q [bira_pkg::HIST_DEPTH];
  logic [bira_pkg::HIST_AW-1:0] wpos_q, wpos_d;
  logic [bira_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic [bira_pkg::SUM_W-1:0]   sum_q, sum_d;

  // Unfilled entries hold zero, so the total over the whole ring equals the
  // total over the filled entries. A write swaps the old entry for the new.
  always_comb begin
    wpos_d = wpos_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (wr_i.we) begin
      sum_d = sum_q - bira_pkg::SUM_W'(ring_q[wpos_q])
            + bira_pkg::SUM_W'(wr_i.rate);
      if (wpos_q == bira_pkg::HIST_AW'(bira_pkg::HIST_DEPTH - 1)) begin
        wpos_d = '0;
      end else begin
        wpos_d = wpos_q + 1'b1;
      end
      if (fill_q != bira_pkg::FILL_W'(bira_pkg::HIST_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      wpos_q <= wpos_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  // Ring entries clear to zero at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bira_pkg::HIST_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      ring_q[wpos_q] <= wr_i.rate;
    end
  end

  assign stat_o.sum    = sum_q;
  assign stat_o.filled = fill_q;

endmodule

@@ rtl/beat_interval_rate_averager_core.sv @@
// Beat interval rate averager top level: controller, registers and outputs.
// Depends on bira_pkg, bira_sdiv, bira_hist and assert_macros.svh.
//
// One sample in, one result out. A sample whose beat is not accepted, or whose
// interval is zero, goes from S_EVAL straight to S_DONE and then to the output
// register. An accepted beat with an interval below 65536 ms first runs the
// bit-serial divider for 60000 / interval in 16 steps, after which it raises
// done. When the rate is not kept, S_CHK goes straight to S_DONE. A kept rate
// runs the divider a second time for the ring total over the fill count. An
// interval of 65536 ms or more skips the first division. After S_DONE the
// controller returns to S_IDLE and only there takes the next sample, so it does
// not take a new sample while one is still in work. The result sits in an
// output register, so the next sample is taken while the previous result still
// waits to be taken. Configuration writes take effect at once; the user must
// make them only while the block is idle, which the block does not enforce.
`include "assert_macros.svh"

module beat_interval_rate_averager_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [bira_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bira_pkg::CFG_W-1:0]          cfg_data_i,
  // Sample channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bira_pkg::IR_W-1:0]           ir_level_i,
  input  logic                                beat_seen_i,
  input  logic [bira_pkg::TIME_W-1:0]         time_ms_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bira_pkg::HR_W-1:0]    heart_rate_o,
  output logic                                beat_accepted_o,
  output logic [bira_pkg::RATE_W-1:0]         rate_stored_o
);

  bira_pkg::state_e             state_q, state_d;

  logic [bira_pkg::IR_W-1:0]    ir_floor_q;
  logic [bira_pkg::DEB_W-1:0]   debounce_q;
  logic [bira_pkg::RATE_W-1:0]  min_rate_q;
  logic [bira_pkg::RATE_W-1:0]  max_rate_q;

  logic [bira_pkg::TIME_W-1:0]  last_q;
  logic [bira_pkg::RATE_W-1:0]  mean_q;

  logic [bira_pkg::IR_W-1:0]    ir_q;
  logic                         beat_q;
  logic [bira_pkg::TIME_W-1:0]  time_q;
  logic                         acc_q;
  logic                         big_q;
  logic [bira_pkg::RATE_W-1:0]  stored_q;

  logic                         out_valid_q;
  logic [bira_pkg::HR_W-1:0]    hr_q;
  logic                         acc_out_q;
  logic [bira_pkg::RATE_W-1:0]  stored_out_q;

  logic [bira_pkg::TIME_W-1:0]  interval;
  logic                         big_c;
  logic                         zero_c;
  logic                         acc_c;
  logic [bira_pkg::DIV_W-1:0]   q_eff;
  logic                         rnz;
  logic                         keep;
  logic                         out_load;

  bira_pkg::div_cmd_t           div_cmd;
  bira_pkg::div_stat_t          div_stat;
  bira_pkg::hist_wr_t           hist_wr;
  bira_pkg::hist_stat_t         hist_stat;

  bira_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .stat_o (div_stat)
  );

  bira_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (hist_wr),
    .stat_o (hist_stat)
  );

  // Beat qualification: IR above floor, interval non-negative and debounced.
  assign interval = time_q - last_q;
  assign big_c    = (interval[bira_pkg::TIME_W-1:bira_pkg::DIV_W] != '0);
  assign zero_c   = (interval == '0);
  assign acc_c    = beat_q && (ir_q > ir_floor_q) && !interval[bira_pkg::TIME_W-1]
                  && (big_c || (interval[bira_pkg::DEB_W-1:0] >= debounce_q));

  // Bounds check from quotient and remainder: min*t <= 60000 holds exactly
  // when min <= q, and max*t >= 60000 when max >= q plus one for a remainder.
  // Intervals beyond the divider width give a zero quotient.
  assign q_eff = big_q ? '0 : div_stat.quot;
  assign rnz   = big_q || (div_stat.rem != '0);
  assign keep  = (bira_pkg::DIV_W'(min_rate_q) <= q_eff)
              && ((bira_pkg::DIV_W + 1)'(max_rate_q)
                  >= ({1'b0, q_eff} + (bira_pkg::DIV_W + 1)'(rnz)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bira_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bira_pkg::S_EVAL;
      end
      bira_pkg::S_EVAL: begin
        if (!acc_c || zero_c) begin
          state_d = bira_pkg::S_DONE;
        end else if (big_c) begin
          state_d = bira_pkg::S_CHK;
        end else begin
          state_d = bira_pkg::S_RDIV;
        end
      end
      bira_pkg::S_RDIV: begin
        if (div_stat.done) state_d = bira_pkg::S_CHK;
      end
      bira_pkg::S_CHK: begin
        state_d = keep ? bira_pkg::S_MSTART : bira_pkg::S_DONE;
      end
      bira_pkg::S_MSTART: begin
        state_d = bira_pkg::S_MDIV;
      end
      bira_pkg::S_MDIV: begin
        if (div_stat.done) state_d = bira_pkg::S_DONE;
      end
      bira_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = bira_pkg::S_IDLE;
      end
      default: state_d = bira_pkg::S_IDLE;
    endcase
  end

  // State outputs: handshake, divider commands and history writes.
  always_comb begin
    in_ready_o       = 1'b0;
    out_load         = 1'b0;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = bira_pkg::RATE_NUM;
    div_cmd.divisor  = interval[bira_pkg::DIV_W-1:0];
    hist_wr.we       = 1'b0;
    hist_wr.rate     = q_eff[bira_pkg::RATE_W-1:0];
    unique case (state_q)
      bira_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
      end
      bira_pkg::S_EVAL: begin
        div_cmd.start = acc_c && !zero_c && !big_c;
      end
      bira_pkg::S_CHK: begin
        hist_wr.we = keep;
      end
      bira_pkg::S_MSTART: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = bira_pkg::DIV_W'(hist_stat.sum);
        div_cmd.divisor  = bira_pkg::DIV_W'(hist_stat.filled);
      end
      bira_pkg::S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bira_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_floor_q <= bira_pkg::IR_FLOOR_RST;
      debounce_q <= bira_pkg::DEBOUNCE_RST;
      min_rate_q <= bira_pkg::MIN_RATE_RST;
      max_rate_q <= bira_pkg::MAX_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (bira_pkg::cfg_reg_e'(cfg_idx_i))
        bira_pkg::REG_IR_FLOOR: ir_floor_q <= cfg_data_i[bira_pkg::IR_W-1:0];
        bira_pkg::REG_DEBOUNCE: debounce_q <= cfg_data_i[bira_pkg::DEB_W-1:0];
        bira_pkg::REG_MIN_RATE: min_rate_q <= cfg_data_i[bira_pkg::RATE_W-1:0];
        bira_pkg::REG_MAX_RATE: max_rate_q <= cfg_data_i[bira_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Persistent beat state: last accepted beat time and current mean.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      mean_q <= '0;
    end else begin
      if (state_q == bira_pkg::S_EVAL && acc_c) begin
        last_q <= time_q;
      end
      if (state_q == bira_pkg::S_MDIV && div_stat.done) begin
        mean_q <= div_stat.quot[bira_pkg::RATE_W-1:0];
      end
    end
  end

  // Per-sample working registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ir_q   <= ir_level_i;
      beat_q <= beat_seen_i;
      time_q <= time_ms_i;
    end
    if (state_q == bira_pkg::S_EVAL) begin
      acc_q    <= acc_c;
      big_q    <= big_c;
      stored_q <= '0;
    end
    if (state_q == bira_pkg::S_CHK && keep) begin
      stored_q <= q_eff[bira_pkg::RATE_W-1:0];
    end
  end

  // Output register: holds one result until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hr_q         <= (hist_stat.filled != '0) ? {1'b0, mean_q} : '1;
      acc_out_q    <= acc_q;
      stored_out_q <= stored_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heart_rate_o    = hr_q;
  assign beat_accepted_o = acc_out_q;
  assign rate_stored_o   = stored_out_q;

  // A nonzero stored rate implies the beat was accepted.
  `BIRA_ASSERT_NOW(a_stored_needs_beat, clk_i, rst_ni, out_valid_o && (rate_stored_o != '0), beat_accepted_o)
  // With an empty history the reported rate is minus one.
  `BIRA_ASSERT_NOW(a_empty_reports_none, clk_i, rst_ni, out_valid_o && (hist_stat.filled == '0), heart_rate_o == '1)
  // The divider only finishes while the controller waits for it.
  `BIRA_ASSERT_NOW(a_div_done_waited, clk_i, rst_ni, div_stat.done, (state_q == bira_pkg::S_RDIV) || (state_q == bira_pkg::S_MDIV))
  // After a history write the fill count is nonzero.
  `BIRA_ASSERT_NEXT(a_write_fills, clk_i, rst_ni, hist_wr.we, hist_stat.filled != '0)

endmodule
